// ===== hdl/cmm_pkg.sv =====
// Shared types and constants for the complex matrix multiply block.
package cmm_pkg;

    localparam int ELEM_BITS = 24;
    localparam int FRAC_BITS = ELEM_BITS - 4;
    localparam int IDX_W     = 3;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;

    typedef struct packed {
        logic [IDX_W-1:0]            row;
        logic [IDX_W-1:0]            column;
        logic signed [ELEM_BITS-1:0] a_re;
        logic signed [ELEM_BITS-1:0] a_im;
        logic signed [ELEM_BITS-1:0] b_re;
        logic signed [ELEM_BITS-1:0] b_im;
        logic                        final_load;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]            out_row;
        logic [IDX_W-1:0]            out_column;
        logic signed [ELEM_BITS-1:0] c_re;
        logic signed [ELEM_BITS-1:0] c_im;
        logic                        end_of_matrix;
    } t_out;

    typedef struct packed {
        logic                        wr;
        logic [ADDR_W-1:0]           addr;
        logic signed [ELEM_BITS-1:0] a_re;
        logic signed [ELEM_BITS-1:0] a_im;
        logic signed [ELEM_BITS-1:0] b_re;
        logic signed [ELEM_BITS-1:0] b_im;
        logic                        run;
    } t_cmd;

endpackage

// ===== hdl/cmm_front.sv =====
// Front end: accepts input words and turns them into store/run commands.
module cmm_front #(
    parameter int DIM = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  cmm_pkg::t_in i_data,
    output logic         o_stall,
    input  logic         i_full,
    output logic         o_push,
    output cmm_pkg::t_cmd o_cmd
);
    import cmm_pkg::*;

    logic w_in_range;

    // registered so that stall never follows valid combinationally
    logic r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b1;
        end else begin
            r_full <= 1'b0;
        end
    end

    assign o_stall = i_full | r_full;
    assign o_push  = i_valid & ~o_stall;

    assign w_in_range = ({1'b0, i_data.row} < (IDX_W + 1)'(DIM))
                      & ({1'b0, i_data.column} < (IDX_W + 1)'(DIM));

    always_comb begin
        o_cmd.wr   = w_in_range;
        o_cmd.addr = ADDR_W'(i_data.row) * ADDR_W'(DIM) + ADDR_W'(i_data.column);
        o_cmd.a_re = i_data.a_re;
        o_cmd.a_im = i_data.a_im;
        o_cmd.b_re = i_data.b_re;
        o_cmd.b_im = i_data.b_im;
        o_cmd.run  = i_data.final_load;
    end

endmodule

// ===== hdl/cmm_queue.sv =====
// Short command queue between the front end and the compute back end.
module cmm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cmm_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output cmm_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import cmm_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hdl/cmm_back.sv =====
// Back end: matrix stores, complex multiply-accumulate pipeline and result register.
module cmm_back #(
    parameter int DIM = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  cmm_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    output cmm_pkg::t_out o_data,
    input  logic          i_stall
);
    import cmm_pkg::*;

    localparam int EB    = ELEM_BITS;
    localparam int AW    = $clog2(DIM * DIM);
    localparam int CW    = $clog2(DIM);
    localparam int ACC_W = 2 * EB + 2 + $clog2(DIM);
    localparam int QW    = ACC_W - FRAC_BITS;
    localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (FRAC_BITS - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    function automatic logic signed [EB-1:0] f_finish(input logic signed [ACC_W-1:0] a);
        logic [ACC_W-1:0] s;
        logic [QW-1:0]    q;
        s = a + ROUND;
        q = s[ACC_W-1:FRAC_BITS];
        if (q[QW-1:EB-1] == '0 || q[QW-1:EB-1] == '1) begin
            return q[EB-1:0];
        end else if (q[QW-1]) begin
            return {1'b1, {(EB - 1){1'b0}}};
        end else begin
            return {1'b0, {(EB - 1){1'b1}}};
        end
    endfunction

    logic [2*EB-1:0] r_mem_a [DIM * DIM];
    logic [2*EB-1:0] r_mem_b [DIM * DIM];

    t_state  r_state;
    logic [CW-1:0] r_i, r_j, r_k;
    logic    w_en, w_run, w_lk, w_lj, w_li;
    logic [AW-1:0] w_a_addr, w_b_addr;

    // stage 1: store read
    logic            r1_v, r1_first, r1_lastk;
    logic [CW-1:0]   r1_i, r1_j;
    logic [2*EB-1:0] r_a_rd, r_b_rd;
    logic signed [EB-1:0] w_ar, w_ai, w_br, w_bi;

    // stage 2: products
    logic            r2_v, r2_first, r2_lastk;
    logic [CW-1:0]   r2_i, r2_j;
    logic signed [2*EB-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [ACC_W-1:0] w_pre, w_pim;

    // stage 3: accumulate
    logic            r3_done;
    logic [CW-1:0]   r3_i, r3_j;
    logic signed [ACC_W-1:0] r_acc_re, r_acc_im;

    logic r_o_valid;
    t_out r_o_data;

    // the whole pipeline advances only while the result register can move
    assign w_en  = ~r_o_valid | ~i_stall;
    assign w_run = (r_state == S_RUN);
    assign o_pop = (r_state == S_IDLE) & ~i_empty;
    assign w_lk  = (r_k == CW'(DIM - 1));
    assign w_lj  = (r_j == CW'(DIM - 1));
    assign w_li  = (r_i == CW'(DIM - 1));

    assign w_a_addr = AW'(r_i) * AW'(DIM) + AW'(r_k);
    assign w_b_addr = AW'(r_k) * AW'(DIM) + AW'(r_j);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop && i_cmd.run) begin
                        r_state <= S_RUN;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                    end
                end
                S_RUN: begin
                    if (w_en) begin
                        if (!w_lk) begin
                            r_k <= r_k + 1'b1;
                        end else begin
                            r_k <= '0;
                            if (!w_lj) begin
                                r_j <= r_j + 1'b1;
                            end else begin
                                r_j <= '0;
                                if (!w_li) begin
                                    r_i <= r_i + 1'b1;
                                end else begin
                                    r_state <= S_IDLE;
                                end
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // stores: written from the queue while idle, read while running
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.wr) begin
            r_mem_a[i_cmd.addr[AW-1:0]] <= {i_cmd.a_re, i_cmd.a_im};
            r_mem_b[i_cmd.addr[AW-1:0]] <= {i_cmd.b_re, i_cmd.b_im};
        end
        if (w_en && w_run) begin
            r_a_rd <= r_mem_a[w_a_addr];
            r_b_rd <= r_mem_b[w_b_addr];
        end
    end

    assign w_ar = r_a_rd[2*EB-1:EB];
    assign w_ai = r_a_rd[EB-1:0];
    assign w_br = r_b_rd[2*EB-1:EB];
    assign w_bi = r_b_rd[EB-1:0];

    assign w_pre = ACC_W'(r_p_rr) - ACC_W'(r_p_ii);
    assign w_pim = ACC_W'(r_p_ri) + ACC_W'(r_p_ir);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v      <= 1'b0;
            r2_v      <= 1'b0;
            r3_done   <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r1_v      <= w_run;
            r2_v      <= r1_v;
            r3_done   <= r2_v & r2_lastk;
            r_o_valid <= r3_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_first <= (r_k == '0);
            r1_lastk <= w_lk;
            r1_i     <= r_i;
            r1_j     <= r_j;

            r2_first <= r1_first;
            r2_lastk <= r1_lastk;
            r2_i     <= r1_i;
            r2_j     <= r1_j;
            r_p_rr   <= w_ar * w_br;
            r_p_ii   <= w_ai * w_bi;
            r_p_ri   <= w_ar * w_bi;
            r_p_ir   <= w_ai * w_br;

            if (r2_v) begin
                r_acc_re <= r2_first ? w_pre : r_acc_re + w_pre;
                r_acc_im <= r2_first ? w_pim : r_acc_im + w_pim;
                r3_i     <= r2_i;
                r3_j     <= r2_j;
            end

            if (r3_done) begin
                r_o_data.out_row       <= IDX_W'(r3_i);
                r_o_data.out_column    <= IDX_W'(r3_j);
                r_o_data.c_re          <= f_finish(r_acc_re);
                r_o_data.c_im          <= f_finish(r_acc_im);
                r_o_data.end_of_matrix <= (r3_i == CW'(DIM - 1)) & (r3_j == CW'(DIM - 1));
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

// ===== hdl/complex_matrix_multiply.sv =====
// Top level of the complex matrix multiply block: front end, command queue, back end.
// Load word: written to the stores by the back end; the front takes one word per cycle until
// the queue fills. Final word: multiply-accumulate on the single complex MAC unit, through the
// store read, product, accumulate and result registers; one result per output element.
// Reset (synchronous, active low) clears the queue, the sequencer and all valid flags;
// the matrix stores keep whatever they held and need no clearing.
module complex_matrix_multiply #(
    parameter int DIM = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cmm_pkg::t_in  i_data,
    output logic          o_stall,
    output logic          o_valid,
    output cmm_pkg::t_out o_data,
    input  logic          i_stall
);
    import cmm_pkg::*;

    // front end -> queue
    logic w_push;
    t_cmd w_push_cmd;
    logic w_full;

    // queue -> back end
    logic w_pop;
    t_cmd w_pop_cmd;
    logic w_empty;

    // Classify each word: store it if the position is in range, flag a run on the last word.
    cmm_front #(
        .DIM (DIM)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    // Hold commands while the back end is busy with a product.
    cmm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_empty (w_empty)
    );

    // Write the stores, run the MAC sequence, round, saturate and drive results.
    cmm_back #(
        .DIM (DIM)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_cmd   (w_pop_cmd),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule
